/* rtl/hex_record_line_parser_core_assert.svh */
// Assertion macros for the checker file of the record line parser.
`ifndef HEX_RECORD_LINE_PARSER_CORE_ASSERT_SVH
`define HEX_RECORD_LINE_PARSER_CORE_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define HRLP_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition is followed by a property in the next cycle.
`define HRLP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* rtl/hrlp_pkg.sv */
`timescale 1ns / 1ps

package hrlp_pkg;

  typedef logic [8:0] pos_t;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam pos_t       DATA_START = 9'd4;
  localparam pos_t       MIN_BYTES  = 9'd5;
  localparam pos_t       POS_SAT    = 9'd261;

  typedef enum logic [1:0] {
    PH_WAIT_COLON = 2'd0,
    PH_DIGITS     = 2'd1,
    PH_TRAIL      = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_COLON     = 3'd1,
    ST_BAD_CHAR     = 3'd2,
    ST_SHORT        = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_ODD_DIGITS   = 3'd5
  } status_t;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       item_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  record_length;
    logic [15:0] load_address;
    logic [7:0]  record_kind;
    logic [7:0]  check_byte;
    logic        sum_ok;
    status_t     line_status;
  } rec_t;

  // Space, tab, CR or LF.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  // Bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

endpackage

/* rtl/hrlp_char_if.sv */
`timescale 1ns / 1ps

interface hrlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink (input valid, input char_code, input end_of_line, output ready);
endinterface

/* rtl/hrlp_rec_if.sv */
`timescale 1ns / 1ps

interface hrlp_rec_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  record_length;
  logic [15:0] load_address;
  logic [7:0]  record_kind;
  logic [7:0]  check_byte;
  logic        sum_ok;
  logic [2:0]  line_status;

  modport source (
    output valid, output item_kind, output payload_byte, output payload_index,
    output record_length, output load_address, output record_kind,
    output check_byte, output sum_ok, output line_status, input ready
  );
  modport sink (
    input valid, input item_kind, input payload_byte, input payload_index,
    input record_length, input load_address, input record_kind,
    input check_byte, input sum_ok, input line_status, output ready
  );
endinterface

/* rtl/hrlp_out_skid.sv */
`timescale 1ns / 1ps

module hrlp_out_skid import hrlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  rec_t        push_rec,
  output logic        can_take,
  hrlp_rec_if.source  rec_out
);

  logic out_valid;
  rec_t out_rec;
  logic skid_valid;
  rec_t skid_rec;
  logic pop;

  assign pop      = out_valid && rec_out.ready;
  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain the spare slot first
      if (pop) begin
        out_rec    <= skid_rec;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_rec   <= push_rec;
        out_valid <= 1'b1;
      end else begin
        skid_rec   <= push_rec;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign rec_out.valid         = out_valid;
  assign rec_out.item_kind     = out_rec.item_kind;
  assign rec_out.payload_byte  = out_rec.payload_byte;
  assign rec_out.payload_index = out_rec.payload_index;
  assign rec_out.record_length = out_rec.record_length;
  assign rec_out.load_address  = out_rec.load_address;
  assign rec_out.record_kind   = out_rec.record_kind;
  assign rec_out.check_byte    = out_rec.check_byte;
  assign rec_out.sum_ok        = out_rec.sum_ok;
  assign rec_out.line_status   = out_rec.line_status;

endmodule

/* rtl/hex_record_line_parser_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Transaction payload
// --------  ---  ---------------------------------------------------------------
// char_in   in   char_code, end_of_line: one character or one line-end marker
// rec_out   out  item_kind, payload_byte, payload_index, record_length,
//                load_address, record_kind, check_byte, sum_ok, line_status
//
// One input transaction per clock cycle while ready; each is decoded in the cycle it is
// accepted and its result (if any) lands at that edge in the output register, or in the
// skid slot while the output register still holds a record that rec_out has not taken.
// The output side is two records deep (output register plus skid slot), so char_in.ready
// drops only when both hold a record that rec_out has not taken.
// rst is synchronous and active high; it returns the parser to "awaiting colon" and
// empties the output slots.

module hex_record_line_parser_core import hrlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hrlp_char_if.sink  char_in,
  hrlp_rec_if.source rec_out
);

  // Line parser state
  phase_t      line_phase,     line_phase_next;
  logic [3:0]  held_nibble,    held_nibble_next;
  logic        nibble_pending, nibble_pending_next;
  pos_t        byte_position,  byte_position_next;
  logic [7:0]  running_sum,    running_sum_next;
  logic [7:0]  count_seen,     count_seen_next;
  logic [15:0] address_seen,   address_seen_next;
  logic [7:0]  type_seen,      type_seen_next;
  logic [7:0]  last_byte_seen, last_byte_seen_next;
  status_t     error_seen,     error_seen_next;

  logic        in_fire;
  logic        take_ok;
  logic        res_valid;
  rec_t        res_rec;

  logic        blank;
  logic [4:0]  nib;
  logic [7:0]  byte_val;
  pos_t        data_pos;
  pos_t        data_end;
  status_t     eol_status;

  assign in_fire       = char_in.valid && char_in.ready;
  assign char_in.ready = take_ok;

  assign blank    = is_blank(char_in.char_code);
  assign nib      = hex_nibble(char_in.char_code);
  assign byte_val = {held_nibble, nib[3:0]};
  assign data_pos = byte_position - DATA_START;
  assign data_end = DATA_START + {1'b0, count_seen};

  // Status at line end: first recorded fault wins, then the structural checks.
  always_comb begin
    eol_status = error_seen;
    if (error_seen == ST_OK) begin
      if (line_phase == PH_WAIT_COLON) begin
        eol_status = ST_NO_COLON;
      end else if (nibble_pending) begin
        eol_status = ST_ODD_DIGITS;
      end else if (byte_position < MIN_BYTES) begin
        eol_status = ST_SHORT;
      end else if (byte_position != ({1'b0, count_seen} + MIN_BYTES)) begin
        eol_status = ST_LEN_MISMATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase     <= PH_WAIT_COLON;
      held_nibble    <= 4'h0;
      nibble_pending <= 1'b0;
      byte_position  <= '0;
      running_sum    <= 8'h00;
      count_seen     <= 8'h00;
      address_seen   <= 16'h0000;
      type_seen      <= 8'h00;
      last_byte_seen <= 8'h00;
      error_seen     <= ST_OK;
    end else begin
      line_phase     <= line_phase_next;
      held_nibble    <= held_nibble_next;
      nibble_pending <= nibble_pending_next;
      byte_position  <= byte_position_next;
      running_sum    <= running_sum_next;
      count_seen     <= count_seen_next;
      address_seen   <= address_seen_next;
      type_seen      <= type_seen_next;
      last_byte_seen <= last_byte_seen_next;
      error_seen     <= error_seen_next;
    end
  end

  always_comb begin
    line_phase_next     = line_phase;
    held_nibble_next    = held_nibble;
    nibble_pending_next = nibble_pending;
    byte_position_next  = byte_position;
    running_sum_next    = running_sum;
    count_seen_next     = count_seen;
    address_seen_next   = address_seen;
    type_seen_next      = type_seen;
    last_byte_seen_next = last_byte_seen;
    error_seen_next     = error_seen;
    res_valid           = 1'b0;
    res_rec             = '0;

    if (in_fire) begin
      if (char_in.end_of_line) begin
        // Close the line: emit the summary and start over.
        res_valid             = 1'b1;
        res_rec.item_kind     = KIND_SUMMARY;
        res_rec.record_length = count_seen;
        res_rec.load_address  = address_seen;
        res_rec.record_kind   = type_seen;
        res_rec.check_byte    = last_byte_seen;
        res_rec.sum_ok        = (eol_status == ST_OK) && (running_sum == 8'h00);
        res_rec.line_status   = eol_status;
        line_phase_next       = PH_WAIT_COLON;
        held_nibble_next      = 4'h0;
        nibble_pending_next   = 1'b0;
        byte_position_next    = '0;
        running_sum_next      = 8'h00;
        count_seen_next       = 8'h00;
        address_seen_next     = 16'h0000;
        type_seen_next        = 8'h00;
        last_byte_seen_next   = 8'h00;
        error_seen_next       = ST_OK;
      end else if (error_seen == ST_OK) begin
        // After a fault, drop every character until the line end.
        unique case (line_phase)
          PH_WAIT_COLON: begin
            if (!blank) begin
              if (char_in.char_code == COLON_CHAR) begin
                line_phase_next = PH_DIGITS;
              end else begin
                error_seen_next = ST_NO_COLON;
              end
            end
          end
          PH_TRAIL: begin
            // Only whitespace may follow the trailing whitespace.
            if (!blank) begin
              error_seen_next = ST_BAD_CHAR;
            end
          end
          PH_DIGITS: begin
            if (blank) begin
              line_phase_next = PH_TRAIL;
            end else if (nib[4]) begin
              error_seen_next = ST_BAD_CHAR;
            end else if (!nibble_pending) begin
              held_nibble_next    = nib[3:0];
              nibble_pending_next = 1'b1;
            end else begin
              // Second digit of the pair: the byte is complete.
              held_nibble_next    = 4'h0;
              nibble_pending_next = 1'b0;
              running_sum_next    = running_sum + byte_val;
              last_byte_seen_next = byte_val;
              if (byte_position == 9'd0) begin
                count_seen_next = byte_val;
              end else if (byte_position == 9'd1) begin
                address_seen_next = {byte_val, address_seen[7:0]};
              end else if (byte_position == 9'd2) begin
                address_seen_next = {address_seen[15:8], byte_val};
              end else if (byte_position == 9'd3) begin
                type_seen_next = byte_val;
              end
              if (byte_position < POS_SAT) begin
                byte_position_next = byte_position + 9'd1;
              end
              // Emit data bytes inside the counted payload only.
              if (byte_position >= DATA_START && byte_position < data_end) begin
                res_valid             = 1'b1;
                res_rec.item_kind     = KIND_DATA;
                res_rec.payload_byte  = byte_val;
                res_rec.payload_index = data_pos[7:0];
              end
            end
          end
          default: begin
            error_seen_next = error_seen;
          end
        endcase
      end
    end
  end

  hrlp_out_skid u_out_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_rec (res_rec),
    .can_take (take_ok),
    .rec_out  (rec_out)
  );

endmodule

/* rtl/hrlp_checker.sv */
`timescale 1ns / 1ps
`include "hex_record_line_parser_core_assert.svh"

module hrlp_checker import hrlp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        item_kind,
  input logic [7:0]  payload_byte,
  input logic [7:0]  payload_index,
  input logic [7:0]  record_length,
  input logic [15:0] load_address,
  input logic [7:0]  record_kind,
  input logic [7:0]  check_byte,
  input logic        sum_ok,
  input logic [2:0]  line_status
);

  logic stalled;
  assign stalled = out_valid && !out_ready;

  // Input may back up only while a record waits at the output.
  `HRLP_ASSERT_CLK(a_ready_low_needs_out, clk, rst, (!in_ready |-> out_valid), "input stalled with empty output")
  // A good checksum flag is only given on an accepted line.
  `HRLP_ASSERT_CLK(a_sum_ok_accepted, clk, rst, (out_valid && sum_ok |-> item_kind == KIND_SUMMARY && line_status == ST_OK), "sum_ok on a rejected line or data byte")
  `HRLP_ASSERT_NEXT(a_valid_holds, clk, rst, stalled, out_valid, "output valid dropped while stalled")
  `HRLP_ASSERT_NEXT(a_payload_holds, clk, rst, stalled, $stable(item_kind) && $stable(payload_byte) && $stable(payload_index) && $stable(record_length) && $stable(load_address) && $stable(record_kind) && $stable(check_byte) && $stable(sum_ok) && $stable(line_status), "output payload changed while stalled")

  logic in_seen;
  assign in_seen = in_valid;

  `HRLP_ASSERT_CLK(a_input_sane, clk, rst, (in_seen && in_ready |-> !(out_valid && out_ready && !in_ready)), "inconsistent input handshake")

endmodule

bind hex_record_line_parser_core hrlp_checker u_hrlp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (char_in.valid),
  .in_ready      (char_in.ready),
  .out_valid     (rec_out.valid),
  .out_ready     (rec_out.ready),
  .item_kind     (rec_out.item_kind),
  .payload_byte  (rec_out.payload_byte),
  .payload_index (rec_out.payload_index),
  .record_length (rec_out.record_length),
  .load_address  (rec_out.load_address),
  .record_kind   (rec_out.record_kind),
  .check_byte    (rec_out.check_byte),
  .sum_ok        (rec_out.sum_ok),
  .line_status   (rec_out.line_status)
);

/* test/hrlp_record_checker.sv */
`timescale 1ns / 1ps

module hrlp_record_checker import hrlp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  hrlp_char_if  chars,
  hrlp_rec_if   recs,
  output int    pending,
  output int    failures,
  output int    summaries_checked,
  output int    data_checked
);

  // Parser state, kept in step with every accepted character.
  phase_t      line_phase_q;
  logic [3:0]  high_nibble;
  logic        half_byte;
  pos_t        bytes_done;
  logic [7:0]  byte_sum;
  logic [7:0]  length_byte;
  logic [15:0] address_word;
  logic [7:0]  kind_byte;
  logic [7:0]  last_byte;
  status_t     first_fault;

  rec_t expected_records[$];
  int   mismatches;
  int   summaries;
  int   data_bytes;

  initial begin
    mismatches = 0;
    summaries  = 0;
    data_bytes = 0;
  end

  function automatic logic blank_char(input logic [7:0] ch);
    return ch == 8'h20 || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A;
  endfunction

  // Upper bit set: not a hex digit.
  function automatic logic [4:0] digit_value(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b0, ch[3:0]};
    if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
      return {1'b0, 4'(ch[3:0] + 4'd9)};
    return 5'h10;
  endfunction

  task automatic clear_line();
    line_phase_q = PH_WAIT_COLON;
    high_nibble  = 4'h0;
    half_byte    = 1'b0;
    bytes_done   = '0;
    byte_sum     = 8'h00;
    length_byte  = 8'h00;
    address_word = 16'h0000;
    kind_byte    = 8'h00;
    last_byte    = 8'h00;
    first_fault  = ST_OK;
  endtask

  task automatic parse_step(input logic [7:0] ch, input logic eol,
                            output logic emit, output rec_t res);
    logic [4:0] dv;
    logic [7:0] b;
    pos_t       p;
    status_t    st;
    res  = '0;
    emit = 1'b0;
    if (eol) begin
      st = first_fault;
      if (st == ST_OK) begin
        if (line_phase_q == PH_WAIT_COLON) st = ST_NO_COLON;
        else if (half_byte) st = ST_ODD_DIGITS;
        else if (bytes_done < MIN_BYTES) st = ST_SHORT;
        else if (bytes_done != {1'b0, length_byte} + MIN_BYTES) st = ST_LEN_MISMATCH;
      end
      res.item_kind     = KIND_SUMMARY;
      res.record_length = length_byte;
      res.load_address  = address_word;
      res.record_kind   = kind_byte;
      res.check_byte    = last_byte;
      res.sum_ok        = (st == ST_OK) && (byte_sum == 8'h00);
      res.line_status   = st;
      emit = 1'b1;
      clear_line();
    end else if (first_fault == ST_OK) begin
      case (line_phase_q)
        PH_WAIT_COLON: begin
          if (!blank_char(ch)) begin
            if (ch == COLON_CHAR) line_phase_q = PH_DIGITS;
            else first_fault = ST_NO_COLON;
          end
        end
        PH_TRAIL: begin
          if (!blank_char(ch)) first_fault = ST_BAD_CHAR;
        end
        default: begin
          dv = digit_value(ch);
          if (blank_char(ch)) begin
            line_phase_q = PH_TRAIL;
          end else if (dv[4]) begin
            first_fault = ST_BAD_CHAR;
          end else if (!half_byte) begin
            high_nibble = dv[3:0];
            half_byte   = 1'b1;
          end else begin
            b           = {high_nibble, dv[3:0]};
            half_byte   = 1'b0;
            high_nibble = 4'h0;
            p           = bytes_done;
            byte_sum    = byte_sum + b;
            last_byte   = b;
            case (p)
              9'd0: length_byte = b;
              9'd1: address_word[15:8] = b;
              9'd2: address_word[7:0] = b;
              9'd3: kind_byte = b;
              default: ;
            endcase
            if (bytes_done < POS_SAT) bytes_done = bytes_done + 9'd1;
            if (p >= DATA_START && p < DATA_START + {1'b0, length_byte}) begin
              res.item_kind     = KIND_DATA;
              res.payload_byte  = b;
              res.payload_index = 8'(p - DATA_START);
              emit = 1'b1;
            end
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rec_t want;
    rec_t next_rec;
    logic emit;
    if (rst) begin
      clear_line();
      expected_records.delete();
    end else begin
      // Compare first: a record leaving now never comes from this edge's character.
      if (recs.valid && recs.ready) begin
        if (expected_records.size() == 0) begin
          $error("record transaction with nothing expected (item_kind %0d)", recs.item_kind);
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          check_field("item_kind", want.item_kind, recs.item_kind);
          check_field("payload_byte", want.payload_byte, recs.payload_byte);
          check_field("payload_index", want.payload_index, recs.payload_index);
          check_field("record_length", want.record_length, recs.record_length);
          check_field("load_address", want.load_address, recs.load_address);
          check_field("record_kind", want.record_kind, recs.record_kind);
          check_field("check_byte", want.check_byte, recs.check_byte);
          check_field("sum_ok", want.sum_ok, recs.sum_ok);
          check_field("line_status", want.line_status, recs.line_status);
          if (want.item_kind == KIND_SUMMARY) summaries++;
          else data_bytes++;
        end
      end
      if (chars.valid && chars.ready) begin
        parse_step(chars.char_code, chars.end_of_line, emit, next_rec);
        if (emit) expected_records.insert(expected_records.size(), next_rec);
      end
    end
    pending           <= expected_records.size();
    failures          <= mismatches;
    summaries_checked <= summaries;
    data_checked      <= data_bytes;
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import hrlp_pkg::*;

  // Stop once this many characters and markers have gone in.
  localparam int ITEM_TARGET = 1400;
  // Far above the slowest legal run: every result held by the stalling receiver.
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  // Shapes of a generated line; all but the first two are malformed.
  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_SUM,
    SHAPE_ODD,
    SHAPE_JUNK,
    SHAPE_INNER_BLANK,
    SHAPE_NO_COLON,
    SHAPE_BAD_LENGTH,
    SHAPE_SHORT,
    SHAPE_EXTRA,
    SHAPE_NOISE,
    SHAPE_EMPTY,
    SHAPE_TRAIL_JUNK
  } line_shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrlp_char_if char_bus ();
  hrlp_rec_if  rec_bus ();

  int pending;
  int failures;
  int summaries_checked;
  int data_checked;

  hex_record_line_parser_core dut (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_bus),
    .rec_out (rec_bus)
  );

  // Predict and compare every record that leaves the parser.
  hrlp_record_checker checker_inst (
    .clk               (clk),
    .rst               (rst),
    .chars             (char_bus),
    .recs              (rec_bus),
    .pending           (pending),
    .failures          (failures),
    .summaries_checked (summaries_checked),
    .data_checked      (data_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Guard against a hang anywhere in the run.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: switch between stall modes after a random stay in each, so that
  // back-pressure lands on data bytes and summaries alike.
  int stall_mode = 0;
  int mode_left  = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: rec_bus.ready <= 1'b1;
      1: rec_bus.ready <= ($urandom_range(0, 1) == 1);
      2: rec_bus.ready <= ($urandom_range(0, 7) == 0);
      default: rec_bus.ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  logic [7:0] line_buf[$];   // characters of the line being built
  logic [7:0] rec_bytes[$];  // decoded bytes of that line
  int burst_left = 0;
  int items_sent = 0;
  int lines_sent = 0;

  // Append one character to the line being built.
  task automatic add_char(input logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endtask

  // Append one decoded byte to the record being built.
  task automatic add_byte(input logic [7:0] b);
    rec_bytes.insert(rec_bytes.size(), b);
  endtask

  // Drive one transaction and hold it until the parser takes it. Between
  // bursts usually drop valid for a random gap.
  task automatic send_item(input logic [7:0] ch, input logic eol);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        char_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    char_bus.valid       <= 1'b1;
    char_bus.char_code   <= ch;
    char_bus.end_of_line <= eol;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  // Send the built line followed by its line-end marker; the marker carries
  // a random character that the parser must ignore.
  task automatic send_line();
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_line();
  endtask

  // Hold off the sender until the parser has delivered everything owed.
  task automatic drain();
    char_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0D;
      default: return 8'h0A;
    endcase
  endfunction

  // Any character that is neither a hex digit nor whitespace.
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66) || c == 8'h20 || c == 8'h09 ||
               c == 8'h0D || c == 8'h0A);
    return c;
  endfunction

  // Hex digit in random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  task automatic append_blanks(input int n);
    repeat (n) add_char(pick_blank());
  endtask

  // Count, address, type, payload, then a checksum that is right or off.
  task automatic make_record(input int count, input logic good_sum);
    logic [7:0] total;
    rec_bytes.delete();
    add_byte(8'(count));
    add_byte(8'($urandom_range(0, 255)));
    add_byte(8'($urandom_range(0, 255)));
    add_byte(8'($urandom_range(0, 255)));
    repeat (count) add_byte(8'($urandom_range(0, 255)));
    total = 8'h00;
    foreach (rec_bytes[i]) total = total + rec_bytes[i];
    if (good_sum) add_byte(8'h00 - total);
    else add_byte(8'h00 - total + 8'($urandom_range(1, 255)));
  endtask

  task automatic build_line(input line_shape_t shape, input int count);
    int first_digit;
    int end_digit;
    int keep;
    logic [7:0] c;
    line_buf.delete();
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 12)) add_char(8'($urandom_range(0, 255)));
      return;
    end
    if (shape == SHAPE_EMPTY) begin
      append_blanks($urandom_range(0, 3));
      return;
    end
    make_record(count, shape != SHAPE_BAD_SUM);
    // Mutate the byte list first.
    case (shape)
      SHAPE_BAD_LENGTH: rec_bytes[0] = rec_bytes[0] + 8'($urandom_range(1, 255));
      SHAPE_SHORT: begin
        keep = $urandom_range(0, 4);
        while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
      end
      SHAPE_EXTRA: begin
        repeat ((count > 200) ? 3 : $urandom_range(1, 4))
          add_byte(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    append_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    add_char(COLON_CHAR);
    first_digit = line_buf.size();
    foreach (rec_bytes[i]) begin
      add_char(hex_char(rec_bytes[i][7:4]));
      add_char(hex_char(rec_bytes[i][3:0]));
    end
    end_digit = line_buf.size();
    // Then mutate the character stream.
    case (shape)
      SHAPE_ODD: line_buf.delete($urandom_range(first_digit, end_digit - 1));
      SHAPE_JUNK: begin
        c = ($urandom_range(0, 3) == 0) ? COLON_CHAR : junk_char();
        line_buf.insert($urandom_range(first_digit, end_digit), c);
      end
      SHAPE_INNER_BLANK: line_buf.insert($urandom_range(first_digit, end_digit - 1),
                                         pick_blank());
      SHAPE_NO_COLON: begin
        do begin
          c = 8'($urandom_range(0, 255));
        end while (c == COLON_CHAR || c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A);
        line_buf[first_digit - 1] = c;
      end
      default: ;
    endcase
    append_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    if (shape == SHAPE_TRAIL_JUNK) begin
      add_char(pick_blank());
      add_char(($urandom_range(0, 1) == 1) ? hex_char(4'($urandom_range(0, 15)))
                                           : junk_char());
    end
  endtask

  // Mostly well-formed records with small payloads; the rest broken.
  task automatic random_line();
    int r;
    int count;
    line_shape_t shape;
    r = $urandom_range(0, 99);
    if (r < 55) shape = SHAPE_GOOD;
    else if (r < 63) shape = SHAPE_BAD_SUM;
    else shape = line_shape_t'(SHAPE_ODD + (r - 63) % 10);
    count = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    build_line(shape, count);
    send_line();
  endtask

  logic big_done = 1'b0;

  initial begin
    char_bus.valid       = 1'b0;
    char_bus.char_code   = 8'h00;
    char_bus.end_of_line = 1'b0;
    rec_bus.ready        = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines: fresh line end, blanks only, missing colon, bare colon,
    // odd digits, end-of-file record, data record in lower case, wrong
    // checksum, non-hex digit, whitespace inside digits, second colon,
    // length mismatch, trimmed blanks, short record, all-ones fields.
    send_item(8'h3A, 1'b1);
    send_text("  \t\r\n");
    send_text("X00000001FF");
    send_text(":");
    send_text(":0");
    send_text(":00000001FF");
    send_text(":0300300002337a1e");
    send_text(":00000001FE");
    send_text(":0G");
    send_text(":00 000001FF");
    send_text("::00");
    send_text(":01000000FF");
    send_text(" \t:00000001FF \r\n");
    send_text(":00000000");
    send_text(":02FFFFFFFFFF04");
    line_buf = '{8'h00, 8'hFF};
    send_line();
    drain();

    // Random part, with one maximal payload that also runs the byte
    // position into saturation.
    while (items_sent < ITEM_TARGET) begin
      if (!big_done && items_sent >= 500) begin
        build_line(SHAPE_EXTRA, 255);
        send_line();
        big_done = 1'b1;
        drain();
      end else begin
        random_line();
      end
    end

    // Wait out everything owed, then keep watching for stray records.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters and line ends in %0d lines.", items_sent, lines_sent);
    $display("Checked %0d record summaries and %0d payload bytes.",
             summaries_checked, data_checked);
    if (failures == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* hex_record_line_parser_core.f */
+incdir+rtl
rtl/hrlp_pkg.sv
rtl/hrlp_char_if.sv
rtl/hrlp_rec_if.sv
rtl/hrlp_out_skid.sv
rtl/hex_record_line_parser_core.sv
rtl/hrlp_checker.sv
test/hrlp_record_checker.sv
test/tb_top.sv
